// ===== rtl/cobd_pkg.sv =====
// Package for the obstacle distance table: payload structs, request codes
// and fixed-point constants. No dependencies.
package cobd_pkg;

   localparam int BINS_DEFAULT = 129;

   localparam int CW    = 36;   // CORDIC datapath width
   localparam int ANG_W = 19;   // angle width, pi = 65536

   localparam logic signed [ANG_W-1:0] ANG_PI      = 19'sd65536;
   localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 19'sd32768;
   localparam logic signed [ANG_W-1:0] STRAIGHT_LO = 19'sd32586;
   localparam logic signed [ANG_W-1:0] STRAIGHT_HI = 19'sd32950;

   localparam logic [17:0] PI_Q16     = 18'd205887;
   localparam logic [15:0] MAXD_RESET = 16'd1280;

   localparam logic [1:0] REQ_CLEAR    = 2'd0;
   localparam logic [1:0] REQ_OBSTACLE = 2'd1;
   localparam logic [1:0] REQ_READ     = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [15:0] obs_x;
      logic signed [15:0] obs_y;
      logic [14:0]        obs_radius;
      logic [7:0]         read_bin;
   } cobd_req_type;

   typedef struct packed {
      logic [7:0]  read_index;
      logic [15:0] read_distance;
   } cobd_rsp_type;

endpackage

// ===== rtl/cobd_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module cobd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 129
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cobd_cordic.sv =====
// Iterative 16-step CORDIC atan2, one micro-rotation per cycle.
// Depends on cobd_pkg.
module cobd_cordic (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [cobd_pkg::CW-1:0]      y_arg,
   input  logic signed [cobd_pkg::CW-1:0]      x_arg,
   output logic                                done,
   output logic signed [cobd_pkg::ANG_W-1:0]   angle
);

   typedef enum logic {C_IDLE, C_RUN} cstate_type;

   cstate_type                          state_ff;
   logic [3:0]                          step_ff;
   logic signed [cobd_pkg::CW-1:0]      xr_ff, yr_ff;
   logic signed [cobd_pkg::ANG_W-1:0]   z_ff;
   logic                                done_ff;
   logic signed [cobd_pkg::CW-1:0]      dx, dy;
   logic signed [cobd_pkg::ANG_W-1:0]   dz;

   function automatic logic [14:0] atan_lut(input logic [3:0] i);
      case (i)
         4'd0:    return 15'd16384;
         4'd1:    return 15'd9672;
         4'd2:    return 15'd5110;
         4'd3:    return 15'd2594;
         4'd4:    return 15'd1302;
         4'd5:    return 15'd652;
         4'd6:    return 15'd326;
         4'd7:    return 15'd163;
         4'd8:    return 15'd81;
         4'd9:    return 15'd41;
         4'd10:   return 15'd20;
         4'd11:   return 15'd10;
         4'd12:   return 15'd5;
         4'd13:   return 15'd3;
         default: return 15'd1;
      endcase
   endfunction

   always_comb begin
      dx = yr_ff >>> step_ff;
      dy = xr_ff >>> step_ff;
      dz = $signed({4'b0, atan_lut(step_ff)});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
         step_ff  <= 4'd0;
      end else begin
         case (state_ff)
            C_IDLE: begin
               done_ff <= start && (y_arg == '0);
               if (start) begin
                  step_ff <= 4'd0;
                  if (y_arg == '0) begin
                     z_ff <= (x_arg >= 0) ? '0 : cobd_pkg::ANG_PI;
                  end else if (x_arg < 0) begin
                     state_ff <= C_RUN;
                     if (y_arg >= 0) begin
                        xr_ff <= y_arg;
                        yr_ff <= -x_arg;
                        z_ff  <= cobd_pkg::ANG_HALF_PI;
                     end else begin
                        xr_ff <= -y_arg;
                        yr_ff <= x_arg;
                        z_ff  <= -cobd_pkg::ANG_HALF_PI;
                     end
                  end else begin
                     state_ff <= C_RUN;
                     xr_ff    <= x_arg;
                     yr_ff    <= y_arg;
                     z_ff     <= '0;
                  end
               end
            end
            C_RUN: begin
               if (yr_ff > 0) begin
                  xr_ff <= xr_ff + dx;
                  yr_ff <= yr_ff - dy;
                  z_ff  <= z_ff + dz;
               end else begin
                  xr_ff <= xr_ff - dx;
                  yr_ff <= yr_ff + dy;
                  z_ff  <= z_ff - dz;
               end
               step_ff <= step_ff + 4'd1;
               done_ff <= (step_ff == 4'd15);
               if (step_ff == 4'd15) begin
                  state_ff <= C_IDLE;
               end
            end
            default: begin
               state_ff <= C_IDLE;
               done_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign done  = done_ff;
   assign angle = z_ff;

endmodule

// ===== rtl/cobd_div.sv =====
// Restoring unsigned divider, 32 by 17 bits, one quotient bit per cycle.
// No dependencies.
module cobd_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [16:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   typedef enum logic {D_IDLE, D_RUN} dstate_type;

   dstate_type  state_ff;
   logic [4:0]  count_ff;
   logic [31:0] quo_ff;
   logic [16:0] rem_ff;
   logic [16:0] div_ff;
   logic        done_ff;
   logic [17:0] trial;
   logic        fits;

   always_comb begin
      trial = {rem_ff, quo_ff[31]};
      fits  = trial >= {1'b0, div_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
         count_ff <= 5'd0;
      end else begin
         case (state_ff)
            D_IDLE: begin
               done_ff <= 1'b0;
               if (start) begin
                  quo_ff   <= dividend;
                  div_ff   <= divisor;
                  rem_ff   <= '0;
                  count_ff <= 5'd0;
                  state_ff <= D_RUN;
               end
            end
            D_RUN: begin
               rem_ff   <= fits ? 17'(trial - {1'b0, div_ff}) : trial[16:0];
               quo_ff   <= {quo_ff[30:0], fits};
               count_ff <= count_ff + 5'd1;
               done_ff  <= (count_ff == 5'd31);
               if (count_ff == 5'd31) begin
                  state_ff <= D_IDLE;
               end
            end
            default: begin
               state_ff <= D_IDLE;
               done_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/curvature_obstacle_distance_bins.sv =====
// Obstacle distance table with one free distance per heading bin over 0..pi.
// A clear rewrites every bin, and a read may wait on the result side. An
// obstacle on a turning path takes four passes of the shared 16-step CORDIC,
// the divider step and steps on the shared 32x18 multiplier, then a
// read-modify-write sweep over the covered bins. A turning path with y at zero
// skips the divider, and a straight path also skips the last CORDIC pass and
// the arc step. After reset a fill pass loads the table before the first
// transaction is taken. Depends on cobd_pkg, cobd_ram, cobd_cordic, cobd_div.
module curvature_obstacle_distance_bins #(
   parameter int BINS = cobd_pkg::BINS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  cobd_pkg::cobd_req_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output cobd_pkg::cobd_rsp_type  rsp_data,
   input  logic                    csr_wr_en,
   input  logic [15:0]             csr_wr_data
);

   localparam int IDXW = $clog2(BINS);
   localparam int CW   = cobd_pkg::CW;
   localparam int AW   = cobd_pkg::ANG_W;

   typedef enum logic [4:0] {
      ST_IDLE, ST_FILL, ST_RD_ISSUE, ST_RD_DATA,
      ST_SQ_X, ST_SQ_Y, ST_SQ_R, ST_BASE,
      ST_B1, ST_B1_WAIT, ST_IDX1, ST_B2, ST_B2_WAIT, ST_IDX2,
      ST_HEAD, ST_HEAD_WAIT, ST_DIV, ST_DIV_WAIT, ST_PHI, ST_PHI_WAIT,
      ST_ARC_P, ST_ARC_HI, ST_ARC_LO, ST_ARC_SUM, ST_SWEEP, ST_SWEEP_END
   } state_type;

   state_type              state_ff;
   logic [15:0]            maxd_ff;
   logic signed [15:0]     x_ff, y_ff;
   logic [14:0]            r_ff;
   logic [7:0]             rb_ff;
   logic                   in_range_ff;
   logic [IDXW-1:0]        fill_addr_ff;
   logic [15:0]            fill_val_ff;
   logic [31:0]            q_ff, base_ff, quot_ff;
   logic                   r_neg_ff;
   logic [16:0]            ang_ff;
   logic [16:0]            phi_ff;
   logic [IDXW-1:0]        idx1_ff, lo_ff, hi_ff, sweep_addr_ff, pend_addr_ff;
   logic                   pend_ff;
   logic [15:0]            d_ff;
   logic [15:0]            frac_ff;
   logic [49:0]            hipi_ff;
   logic [49:0]            mul_p_ff;
   logic [49:0]            mul_p_in;
   logic                   rsp_valid_ff;
   cobd_pkg::cobd_rsp_type rsp_data_ff;

   logic [31:0]            mul_a;
   logic [17:0]            mul_b;
   logic [15:0]            x_abs, y_abs;
   logic signed [CW-1:0]   x_w, y_w, r_w;
   logic                   cord_start, cord_done;
   logic signed [CW-1:0]   cord_y, cord_x;
   logic signed [AW-1:0]   cord_z;
   logic                   div_start, div_done;
   logic [31:0]            div_q;
   logic                   ram_we, ram_re;
   logic [IDXW-1:0]        ram_waddr, ram_raddr;
   logic [15:0]            ram_wdata, ram_rdata;
   logic                   accept;
   logic [31:0]            rb_ext;
   logic [31:0]            idx_sum;
   logic [IDXW-1:0]        idx_new;
   logic [16:0]            ang_clamped;
   logic signed [AW-1:0]   th;
   logic                   straight;
   logic [15:0]            straight_d;
   logic [49:0]            arc_sum;
   logic [15:0]            arc_d;

   function automatic logic [15:0] sat_dist(input logic signed [CW-1:0] v,
                                            input logic [15:0] lim);
      if (v < 0) begin
         return 16'd0;
      end
      if (v > $signed({{(CW-16){1'b0}}, lim})) begin
         return lim;
      end
      return v[15:0];
   endfunction

   always_comb begin
      accept   = req_valid && !req_stall;
      x_abs    = x_ff[15] ? (~x_ff + 16'd1) : x_ff;
      y_abs    = y_ff[15] ? (~y_ff + 16'd1) : y_ff;
      x_w      = {{(CW-16){x_ff[15]}}, x_ff};
      y_w      = {{(CW-16){y_ff[15]}}, y_ff};
      r_w      = {{(CW-15){1'b0}}, r_ff};
      rb_ext   = {24'b0, rb_ff};
      idx_sum  = mul_p_ff[31:0] + 32'd32768;
      idx_new  = idx_sum[16 +: IDXW];
      if (cord_z < 0) begin
         ang_clamped = 17'd0;
      end else if (cord_z > cobd_pkg::ANG_PI) begin
         ang_clamped = 17'd65536;
      end else begin
         ang_clamped = cord_z[16:0];
      end
      th       = (y_ff == 16'sd0 && q_ff != 32'd0) ? cobd_pkg::ANG_HALF_PI : cord_z;
      straight = (th >= cobd_pkg::STRAIGHT_LO) && (th <= cobd_pkg::STRAIGHT_HI);
      straight_d = (x_ff <= 16'sd0) ? maxd_ff : sat_dist(x_w - r_w, maxd_ff);
      arc_sum  = hipi_ff + {16'b0, mul_p_ff[49:16]};
      arc_d    = sat_dist($signed({2'b0, arc_sum[49:16]}) - r_w, maxd_ff);
   end

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQ_X: begin
            mul_a = {16'b0, x_abs};
            mul_b = {2'b0, x_abs};
         end
         ST_SQ_Y: begin
            mul_a = {16'b0, y_abs};
            mul_b = {2'b0, y_abs};
         end
         ST_SQ_R: begin
            mul_a = {17'b0, r_ff};
            mul_b = {3'b0, r_ff};
         end
         ST_IDX1, ST_IDX2: begin
            mul_a = 32'(BINS - 1);
            mul_b = {1'b0, ang_ff};
         end
         ST_ARC_P: begin
            mul_a = quot_ff;
            mul_b = {1'b0, phi_ff};
         end
         ST_ARC_HI: begin
            mul_a = mul_p_ff[47:16];
            mul_b = cobd_pkg::PI_Q16;
         end
         ST_ARC_LO: begin
            mul_a = {16'b0, frac_ff};
            mul_b = cobd_pkg::PI_Q16;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p_in = mul_a * mul_b;
   end

   always_comb begin
      cord_start = 1'b0;
      cord_y     = '0;
      cord_x     = '0;
      case (state_ff)
         ST_B1: begin
            cord_start = 1'b1;
            cord_y     = {{(CW-32){1'b0}}, base_ff};
            cord_x     = (y_w + r_w) <<< 9;
         end
         ST_B2: begin
            cord_start = 1'b1;
            cord_y     = {{(CW-32){1'b0}}, base_ff};
            cord_x     = (y_w - r_w) <<< 9;
         end
         ST_HEAD: begin
            cord_start = 1'b1;
            cord_y     = {{(CW-32){1'b0}}, q_ff};
            cord_x     = y_w <<< 9;
         end
         ST_PHI: begin
            cord_start = 1'b1;
            cord_y     = x_w;
            cord_x     = r_neg_ff ? (y_w + $signed({{(CW-32){1'b0}}, quot_ff}))
                                  : ($signed({{(CW-32){1'b0}}, quot_ff}) - y_w);
         end
         default: begin
            cord_start = 1'b0;
         end
      endcase
      div_start = (state_ff == ST_DIV);
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = pend_addr_ff;
      ram_wdata = d_ff;
      ram_re    = 1'b0;
      ram_raddr = sweep_addr_ff;
      case (state_ff)
         ST_FILL: begin
            ram_we    = 1'b1;
            ram_waddr = fill_addr_ff;
            ram_wdata = fill_val_ff;
         end
         ST_RD_ISSUE: begin
            ram_re    = 1'b1;
            ram_raddr = rb_ext[IDXW-1:0];
         end
         ST_SWEEP: begin
            ram_re = 1'b1;
            ram_we = pend_ff && (ram_rdata > d_ff);
         end
         ST_SWEEP_END: begin
            ram_we = pend_ff && (ram_rdata > d_ff);
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mul_p_ff <= mul_p_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         fill_addr_ff <= '0;
         fill_val_ff  <= cobd_pkg::MAXD_RESET;
         maxd_ff      <= cobd_pkg::MAXD_RESET;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            maxd_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_RD_DATA) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  x_ff  <= req_data.obs_x;
                  y_ff  <= req_data.obs_y;
                  r_ff  <= req_data.obs_radius;
                  rb_ff <= req_data.read_bin;
                  case (req_data.req_type)
                     cobd_pkg::REQ_CLEAR: begin
                        fill_addr_ff <= '0;
                        fill_val_ff  <= maxd_ff;
                        state_ff     <= ST_FILL;
                     end
                     cobd_pkg::REQ_OBSTACLE: state_ff <= ST_SQ_X;
                     cobd_pkg::REQ_READ:     state_ff <= ST_RD_ISSUE;
                     default:                state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_FILL: begin
               fill_addr_ff <= fill_addr_ff + 1'b1;
               if (fill_addr_ff == IDXW'(BINS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_RD_ISSUE: begin
               in_range_ff <= rb_ext < 32'(BINS);
               state_ff    <= ST_RD_DATA;
            end
            ST_RD_DATA: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_data_ff.read_index    <= rb_ff;
                  rsp_data_ff.read_distance <= in_range_ff ? ram_rdata : 16'd0;
                  rsp_valid_ff              <= 1'b1;
                  state_ff                  <= ST_IDLE;
               end
            end
            ST_SQ_X: state_ff <= ST_SQ_Y;
            ST_SQ_Y: begin
               q_ff     <= mul_p_ff[31:0];
               state_ff <= ST_SQ_R;
            end
            ST_SQ_R: begin
               q_ff     <= q_ff + mul_p_ff[31:0];
               state_ff <= ST_BASE;
            end
            ST_BASE: begin
               base_ff  <= (q_ff >= mul_p_ff[31:0]) ? (q_ff - mul_p_ff[31:0]) : 32'd0;
               state_ff <= ST_B1;
            end
            ST_B1: state_ff <= ST_B1_WAIT;
            ST_B1_WAIT: begin
               if (cord_done) begin
                  ang_ff   <= ang_clamped;
                  state_ff <= ST_IDX1;
               end
            end
            ST_IDX1: state_ff <= ST_B2;
            ST_B2: begin
               idx1_ff  <= idx_new;
               state_ff <= ST_B2_WAIT;
            end
            ST_B2_WAIT: begin
               if (cord_done) begin
                  ang_ff   <= ang_clamped;
                  state_ff <= ST_IDX2;
               end
            end
            ST_IDX2: state_ff <= ST_HEAD;
            ST_HEAD: begin
               if (idx_new < idx1_ff) begin
                  lo_ff <= idx_new;
                  hi_ff <= idx1_ff;
               end else begin
                  lo_ff <= idx1_ff;
                  hi_ff <= idx_new;
               end
               state_ff <= ST_HEAD_WAIT;
            end
            ST_HEAD_WAIT: begin
               if (cord_done) begin
                  if (straight) begin
                     d_ff          <= straight_d;
                     sweep_addr_ff <= lo_ff;
                     state_ff      <= ST_SWEEP;
                  end else if (y_ff == 16'sd0) begin
                     quot_ff  <= 32'd0;
                     r_neg_ff <= 1'b0;
                     state_ff <= ST_PHI;
                  end else begin
                     state_ff <= ST_DIV;
                  end
               end
            end
            ST_DIV: state_ff <= ST_DIV_WAIT;
            ST_DIV_WAIT: begin
               if (div_done) begin
                  quot_ff  <= div_q;
                  r_neg_ff <= y_ff[15] && (div_q != 32'd0);
                  state_ff <= ST_PHI;
               end
            end
            ST_PHI: state_ff <= ST_PHI_WAIT;
            ST_PHI_WAIT: begin
               if (cord_done) begin
                  phi_ff   <= (cord_z < 0) ? 17'(cord_z + (cobd_pkg::ANG_PI <<< 1))
                                           : cord_z[16:0];
                  state_ff <= ST_ARC_P;
               end
            end
            ST_ARC_P: state_ff <= ST_ARC_HI;
            ST_ARC_HI: begin
               frac_ff  <= mul_p_ff[15:0];
               state_ff <= ST_ARC_LO;
            end
            ST_ARC_LO: begin
               hipi_ff  <= mul_p_ff;
               state_ff <= ST_ARC_SUM;
            end
            ST_ARC_SUM: begin
               d_ff          <= arc_d;
               sweep_addr_ff <= lo_ff;
               state_ff      <= ST_SWEEP;
            end
            ST_SWEEP: begin
               pend_ff      <= 1'b1;
               pend_addr_ff <= sweep_addr_ff;
               if (sweep_addr_ff == hi_ff) begin
                  state_ff <= ST_SWEEP_END;
               end else begin
                  sweep_addr_ff <= sweep_addr_ff + 1'b1;
               end
            end
            ST_SWEEP_END: begin
               pend_ff  <= 1'b0;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   cobd_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cord_start),
      .y_arg (cord_y),
      .x_arg (cord_x),
      .done  (cord_done),
      .angle (cord_z)
   );

   cobd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (q_ff),
      .divisor  ({y_abs, 1'b0}),
      .done     (div_done),
      .quotient (div_q)
   );

   cobd_ram #(
      .WIDTH (16),
      .DEPTH (BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule
